// File: design/asas_pkg.sv
// shared types, constants and register map of the audio source auto selector
package asas_pkg;

  // counter and bus widths
  localparam int PRESC_W = 24;
  localparam int TIMER_W = 16;
  localparam int APB_AW  = 5;
  localparam int APB_DW  = 32;

  // request function codes
  typedef enum logic [1:0] {
    FUNC_TICK    = 2'd0,
    FUNC_TOGGLE  = 2'd1,
    FUNC_TEMP_BT = 2'd2,
    FUNC_RSVD    = 2'd3
  } func_t;

  // register indexes (byte address is four times the index)
  localparam logic [2:0] REG_STARTUP_HOLD    = 3'd0;
  localparam logic [2:0] REG_POLL_RELOAD     = 3'd1;
  localparam logic [2:0] REG_FALLBACK_POLLS  = 3'd2;
  localparam logic [2:0] REG_BT_WAKE_HOLD    = 3'd3;
  localparam logic [2:0] REG_TEMP_BT_HOLD    = 3'd4;

  // register reset values
  localparam logic [PRESC_W-1:0] RST_STARTUP_HOLD   = 24'd23500;
  localparam logic [TIMER_W-1:0] RST_POLL_RELOAD    = 16'd100;
  localparam logic [TIMER_W-1:0] RST_FALLBACK_POLLS = 16'd600;
  localparam logic [TIMER_W-1:0] RST_BT_WAKE_HOLD   = 16'd20000;
  localparam logic [TIMER_W-1:0] RST_TEMP_BT_HOLD   = 16'd15000;

  // configuration seen by the control logic
  typedef struct packed {
    logic [PRESC_W-1:0] startup_hold_ticks;
    logic [TIMER_W-1:0] poll_reload_ticks;
    logic [TIMER_W-1:0] radio_fallback_polls;
    logic [TIMER_W-1:0] bt_wake_hold_ticks;
    logic [TIMER_W-1:0] temp_bt_hold_ticks;
  } cfg_t;

  // one input request
  typedef struct packed {
    logic [1:0] func;
    logic       bt_powered;
    logic       bt_linked;
    logic       call_active;
  } item_t;

  // one result
  typedef struct packed {
    logic mux_sel_a;
    logic mux_sel_b;
    logic bt_power_request;
  } result_t;

endpackage

// File: design/asas_if.sv
// valid/ready channel interfaces for requests and results

// request channel
interface asas_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic       bt_powered;
  logic       bt_linked;
  logic       call_active;

  modport source (output valid, func, bt_powered, bt_linked, call_active, input ready);
  modport sink   (input valid, func, bt_powered, bt_linked, call_active, output ready);
endinterface

// result channel
interface asas_out_if;
  logic valid;
  logic ready;
  logic mux_sel_a;
  logic mux_sel_b;
  logic bt_power_request;

  modport source (output valid, mux_sel_a, mux_sel_b, bt_power_request, input ready);
  modport sink   (input valid, mux_sel_a, mux_sel_b, bt_power_request, output ready);
endinterface

// File: design/asas_cfg_regs.sv
// APB configuration registers of the audio source auto selector
module asas_cfg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [asas_pkg::APB_AW-1:0] paddr,
  input  logic [asas_pkg::APB_DW-1:0] pwdata,
  output logic [asas_pkg::APB_DW-1:0] prdata,
  output logic                        pready,
  output asas_pkg::cfg_t              cfg
);

  asas_pkg::cfg_t cfg_r;
  logic [2:0]     reg_idx;
  logic           wr_en;

  assign reg_idx = paddr[asas_pkg::APB_AW-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.startup_hold_ticks   <= asas_pkg::RST_STARTUP_HOLD;
      cfg_r.poll_reload_ticks    <= asas_pkg::RST_POLL_RELOAD;
      cfg_r.radio_fallback_polls <= asas_pkg::RST_FALLBACK_POLLS;
      cfg_r.bt_wake_hold_ticks   <= asas_pkg::RST_BT_WAKE_HOLD;
      cfg_r.temp_bt_hold_ticks   <= asas_pkg::RST_TEMP_BT_HOLD;
    end else if (wr_en) begin
      case (reg_idx)
        asas_pkg::REG_STARTUP_HOLD:
          cfg_r.startup_hold_ticks <= pwdata[asas_pkg::PRESC_W-1:0];
        asas_pkg::REG_POLL_RELOAD:
          cfg_r.poll_reload_ticks <= pwdata[asas_pkg::TIMER_W-1:0];
        asas_pkg::REG_FALLBACK_POLLS:
          cfg_r.radio_fallback_polls <= pwdata[asas_pkg::TIMER_W-1:0];
        asas_pkg::REG_BT_WAKE_HOLD:
          cfg_r.bt_wake_hold_ticks <= pwdata[asas_pkg::TIMER_W-1:0];
        asas_pkg::REG_TEMP_BT_HOLD:
          cfg_r.temp_bt_hold_ticks <= pwdata[asas_pkg::TIMER_W-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (reg_idx)
      asas_pkg::REG_STARTUP_HOLD:
        prdata = asas_pkg::APB_DW'(cfg_r.startup_hold_ticks);
      asas_pkg::REG_POLL_RELOAD:
        prdata = asas_pkg::APB_DW'(cfg_r.poll_reload_ticks);
      asas_pkg::REG_FALLBACK_POLLS:
        prdata = asas_pkg::APB_DW'(cfg_r.radio_fallback_polls);
      asas_pkg::REG_BT_WAKE_HOLD:
        prdata = asas_pkg::APB_DW'(cfg_r.bt_wake_hold_ticks);
      asas_pkg::REG_TEMP_BT_HOLD:
        prdata = asas_pkg::APB_DW'(cfg_r.temp_bt_hold_ticks);
      default:
        prdata = '0;
    endcase
  end

endmodule

// File: design/asas_ctrl.sv
// source selection state and its single-pass next-state logic
module asas_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step_en,
  input  asas_pkg::item_t     item,
  input  asas_pkg::cfg_t      cfg,
  output asas_pkg::result_t   res
);

  logic [asas_pkg::PRESC_W-1:0] presc_r, presc_nxt;
  logic [asas_pkg::TIMER_W-1:0] fb_timer_r, fb_timer_nxt;
  logic                         src_bt_r, src_bt_nxt;
  logic                         link_up_r, link_up_nxt;
  logic                         in_call_r, in_call_nxt;
  logic                         saved_bt_r, saved_bt_nxt;
  logic                         pwr_req;

  // next state for the request under way
  always_comb begin
    presc_nxt    = presc_r;
    fb_timer_nxt = fb_timer_r;
    src_bt_nxt   = src_bt_r;
    link_up_nxt  = link_up_r;
    in_call_nxt  = in_call_r;
    saved_bt_nxt = saved_bt_r;
    pwr_req      = 1'b0;
    unique case (asas_pkg::func_t'(item.func))
      asas_pkg::FUNC_TICK: begin
        if (presc_r != '0) begin
          presc_nxt = presc_r - asas_pkg::PRESC_W'(1);
        end else begin
          // poll
          presc_nxt = asas_pkg::PRESC_W'(cfg.poll_reload_ticks);
          if (!item.bt_powered) begin
            src_bt_nxt  = 1'b0;
            link_up_nxt = 1'b0;
          end else begin
            // fallback timer: arm, count down, fall back to radio on expiry
            if (src_bt_r && !item.bt_linked && (fb_timer_r == '0)) begin
              fb_timer_nxt = cfg.radio_fallback_polls;
            end
            if (fb_timer_nxt != '0) begin
              fb_timer_nxt = fb_timer_nxt - asas_pkg::TIMER_W'(1);
              if ((fb_timer_nxt == '0) && !item.bt_linked) begin
                src_bt_nxt = 1'b0;
              end
            end
            // lost link came back
            if (!link_up_r && !src_bt_nxt && !in_call_r && item.bt_linked) begin
              src_bt_nxt  = 1'b1;
              link_up_nxt = 1'b1;
            end
            if (!item.bt_linked) begin
              link_up_nxt = 1'b0;
            end
            // call handling: force bluetooth, restore afterwards
            if (item.call_active) begin
              if (!in_call_r) begin
                in_call_nxt  = 1'b1;
                saved_bt_nxt = src_bt_nxt;
              end
              if (!src_bt_nxt) begin
                src_bt_nxt  = 1'b1;
                link_up_nxt = 1'b1;
              end
            end else if (in_call_r) begin
              in_call_nxt = 1'b0;
              if (saved_bt_r) begin
                src_bt_nxt  = 1'b1;
                link_up_nxt = 1'b1;
              end else begin
                src_bt_nxt = 1'b0;
              end
            end
          end
        end
      end
      asas_pkg::FUNC_TOGGLE: begin
        if (src_bt_r) begin
          src_bt_nxt = 1'b0;
        end else begin
          src_bt_nxt  = 1'b1;
          link_up_nxt = 1'b1;
          if (!item.bt_powered) begin
            pwr_req   = 1'b1;
            presc_nxt = asas_pkg::PRESC_W'(cfg.bt_wake_hold_ticks);
          end
        end
      end
      asas_pkg::FUNC_TEMP_BT: begin
        presc_nxt   = asas_pkg::PRESC_W'(cfg.temp_bt_hold_ticks);
        src_bt_nxt  = 1'b1;
        link_up_nxt = 1'b1;
      end
      asas_pkg::FUNC_RSVD: begin
      end
    endcase
  end

  // result follows the updated source
  assign res.mux_sel_a        = src_bt_nxt;
  assign res.mux_sel_b        = src_bt_nxt;
  assign res.bt_power_request = pwr_req;

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      presc_r    <= asas_pkg::RST_STARTUP_HOLD;
      fb_timer_r <= '0;
      src_bt_r   <= 1'b1;
      link_up_r  <= 1'b1;
      in_call_r  <= 1'b0;
      saved_bt_r <= 1'b1;
    end else if (step_en) begin
      presc_r    <= presc_nxt;
      fb_timer_r <= fb_timer_nxt;
      src_bt_r   <= src_bt_nxt;
      link_up_r  <= link_up_nxt;
      in_call_r  <= in_call_nxt;
      saved_bt_r <= saved_bt_nxt;
    end
  end

  // temporary switch always lands on bluetooth
  a_temp_bt_selects: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && (item.func == asas_pkg::FUNC_TEMP_BT) |=> src_bt_r)
    else $error("temporary switch did not select bluetooth");

  // a non-zero prescaler counts down by one on a tick
  a_presc_count: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && (item.func == asas_pkg::FUNC_TICK) && (presc_r != '0)
    |=> presc_r == $past(presc_r) - asas_pkg::PRESC_W'(1))
    else $error("prescaler did not count down");

  // state holds when no request is processed
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !step_en && $past(rst_n) |=> $stable(presc_r) && $stable(src_bt_r) && $stable(fb_timer_r))
    else $error("state changed without a request");

endmodule

// File: design/audio_source_auto_selector.sv
// top level of the audio source auto selector: request register, control, result register
// A request is held in the request register, passes the control logic into the result register
// and is then presented on out_ch from there.
// Throughput: one request per cycle; when out_ch stalls, both registers fill and
// in_ch.ready drops in that same cycle, since it follows out_ch.ready through advance.
// Each request is resolved in a single pass of the control logic between the two registers.
// Reset: synchronous, active low; registers take their defaults, the prescaler loads the
// default startup hold, bluetooth is selected and both pipeline registers are emptied.
module audio_source_auto_selector (
  input  logic                        clk,
  input  logic                        rst_n,
  asas_in_if.sink                     in_ch,
  asas_out_if.source                  out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [asas_pkg::APB_AW-1:0] paddr,
  input  logic [asas_pkg::APB_DW-1:0] pwdata,
  output logic [asas_pkg::APB_DW-1:0] prdata,
  output logic                        pready
);

  asas_pkg::cfg_t    cfg;
  asas_pkg::item_t   item_r;
  asas_pkg::result_t res;
  asas_pkg::result_t res_r;
  logic              in_vld_r;
  logic              out_vld_r;
  logic              advance;

  // configuration registers
  asas_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // request moves on when the result register is free or being emptied
  assign advance     = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready = !in_vld_r || advance;

  // request register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item_r.func        <= in_ch.func;
      item_r.bt_powered  <= in_ch.bt_powered;
      item_r.bt_linked   <= in_ch.bt_linked;
      item_r.call_active <= in_ch.call_active;
    end
  end

  // selection control
  asas_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .item    (item_r),
    .cfg     (cfg),
    .res     (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_ch.valid            = out_vld_r;
  assign out_ch.mux_sel_a        = res_r.mux_sel_a;
  assign out_ch.mux_sel_b        = res_r.mux_sel_b;
  assign out_ch.bt_power_request = res_r.bt_power_request;

  // both select lines always agree
  a_sel_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> res_r.mux_sel_a == res_r.mux_sel_b)
    else $error("mux select lines disagree");

  // a power request only comes with bluetooth selected
  a_req_bt: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && res_r.bt_power_request |-> res_r.mux_sel_a)
    else $error("power request without bluetooth selected");

  // a request in the input stage always leaves it once the result side drains
  a_no_stall_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && !out_vld_r |-> advance)
    else $error("request held while the result register is empty");

endmodule

// File: tb/tb.sv
// self-checking testbench for the audio source auto selector
`timescale 1ns / 100ps

module tb;

  // one row of the directed table
  typedef struct {
    asas_pkg::item_t   req;
    bit                typed;
    asas_pkg::result_t res;
  } step_t;

  localparam int STALL_LIMIT  = 3000;
  localparam int LONG_HOLD    = 400;
  localparam int PHASE_ITEMS  = 280;
  localparam int RANDOM_PHASES = 6;

  logic                        clk;
  logic                        rst_n;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [asas_pkg::APB_AW-1:0] paddr;
  logic [asas_pkg::APB_DW-1:0] pwdata;
  logic [asas_pkg::APB_DW-1:0] prdata;
  logic                        pready;

  asas_in_if  in_ch ();
  asas_out_if out_ch ();

  audio_source_auto_selector i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // selector model state and register shadow
  asas_pkg::cfg_t               cfg_shadow;
  logic [asas_pkg::PRESC_W-1:0] presc_count;
  logic [asas_pkg::TIMER_W-1:0] fallback_left;
  bit                           on_bt;
  bit                           link_seen;
  bit                           call_held;
  bit                           bt_before_call;

  asas_pkg::result_t pending_selections [$];
  asas_pkg::result_t oldest_selection;

  // line conditions that persist across requests
  bit line_powered;
  bit line_linked;
  bit line_call;

  bit steady_flow;
  bit hold_off_req;
  int fail_count;
  int requests_sent;
  int results_seen;
  int poll_count;
  int power_req_count;
  int settings_used;
  int idle_cycles;

  // directed rows, run with zero wake and temporary holds, zero reload and one fallback poll
  step_t directed_steps [16] = '{
    '{'{asas_pkg::FUNC_RSVD,    1'b1, 1'b1, 1'b0}, 1'b1, '{1'b1, 1'b1, 1'b0}},
    '{'{asas_pkg::FUNC_TICK,    1'b0, 1'b0, 1'b0}, 1'b1, '{1'b1, 1'b1, 1'b0}},
    '{'{asas_pkg::FUNC_TOGGLE,  1'b1, 1'b1, 1'b0}, 1'b1, '{1'b0, 1'b0, 1'b0}},
    '{'{asas_pkg::FUNC_TOGGLE,  1'b0, 1'b0, 1'b0}, 1'b1, '{1'b1, 1'b1, 1'b1}},
    '{'{asas_pkg::FUNC_TICK,    1'b0, 1'b0, 1'b0}, 1'b0, '0},
    '{'{asas_pkg::FUNC_TICK,    1'b1, 1'b1, 1'b0}, 1'b0, '0},
    '{'{asas_pkg::FUNC_TICK,    1'b1, 1'b0, 1'b0}, 1'b0, '0},
    '{'{asas_pkg::FUNC_TICK,    1'b1, 1'b0, 1'b1}, 1'b0, '0},
    '{'{asas_pkg::FUNC_TICK,    1'b1, 1'b0, 1'b1}, 1'b0, '0},
    '{'{asas_pkg::FUNC_TICK,    1'b1, 1'b1, 1'b0}, 1'b0, '0},
    '{'{asas_pkg::FUNC_TEMP_BT, 1'b0, 1'b1, 1'b1}, 1'b1, '{1'b1, 1'b1, 1'b0}},
    '{'{asas_pkg::FUNC_TOGGLE,  1'b1, 1'b0, 1'b1}, 1'b0, '0},
    '{'{asas_pkg::FUNC_TOGGLE,  1'b1, 1'b1, 1'b1}, 1'b0, '0},
    '{'{asas_pkg::FUNC_TICK,    1'b1, 1'b1, 1'b1}, 1'b0, '0},
    '{'{asas_pkg::FUNC_RSVD,    1'b0, 1'b0, 1'b0}, 1'b0, '0},
    '{'{asas_pkg::FUNC_TOGGLE,  1'b0, 1'b1, 1'b0}, 1'b0, '0}
  };

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // source selection for one request, advancing the model state
  function automatic asas_pkg::result_t select_source(asas_pkg::item_t req);
    asas_pkg::result_t res;
    bit                powered;
    bit                linked;
    bit                call;
    powered = req.bt_powered;
    linked  = req.bt_linked;
    call    = req.call_active;
    res.bt_power_request = 1'b0;
    case (asas_pkg::func_t'(req.func))
      asas_pkg::FUNC_TICK: begin
        if (presc_count != 0) begin
          presc_count = presc_count - 1'b1;
        end else begin
          poll_count++;
          presc_count = asas_pkg::PRESC_W'(cfg_shadow.poll_reload_ticks);
          if (!powered) begin
            on_bt     = 1'b0;
            link_seen = 1'b0;
          end else begin
            // fallback timer arms while unlinked on bluetooth and stops at zero
            if (on_bt && !linked && fallback_left == 0)
              fallback_left = cfg_shadow.radio_fallback_polls;
            if (fallback_left != 0) begin
              fallback_left = fallback_left - 1'b1;
              if (fallback_left == 0 && !linked)
                on_bt = 1'b0;
            end
            // lost link came back
            if (!link_seen && !on_bt && !call_held && linked) begin
              on_bt     = 1'b1;
              link_seen = 1'b1;
            end
            if (!linked)
              link_seen = 1'b0;
            // call forces bluetooth, then the earlier source returns
            if (call) begin
              if (!call_held) begin
                call_held      = 1'b1;
                bt_before_call = on_bt;
              end
              if (!on_bt) begin
                on_bt     = 1'b1;
                link_seen = 1'b1;
              end
            end else if (call_held) begin
              call_held = 1'b0;
              if (bt_before_call) begin
                on_bt     = 1'b1;
                link_seen = 1'b1;
              end else begin
                on_bt = 1'b0;
              end
            end
          end
        end
      end
      asas_pkg::FUNC_TOGGLE: begin
        if (on_bt) begin
          on_bt = 1'b0;
        end else begin
          on_bt     = 1'b1;
          link_seen = 1'b1;
          if (!powered) begin
            res.bt_power_request = 1'b1;
            presc_count          = asas_pkg::PRESC_W'(cfg_shadow.bt_wake_hold_ticks);
            power_req_count++;
          end
        end
      end
      asas_pkg::FUNC_TEMP_BT: begin
        presc_count = asas_pkg::PRESC_W'(cfg_shadow.temp_bt_hold_ticks);
        on_bt       = 1'b1;
        link_seen   = 1'b1;
      end
      default: ;
    endcase
    res.mux_sel_a = on_bt;
    res.mux_sel_b = on_bt;
    return res;
  endfunction

  // random request: mostly ticks under slowly changing line conditions, a little noise
  function automatic asas_pkg::item_t next_request();
    asas_pkg::item_t req;
    int              pick;
    if (line_powered ? ($urandom_range(0, 59) == 0) : ($urandom_range(0, 7) == 0))
      line_powered = !line_powered;
    if ($urandom_range(0, 24) == 0)
      line_linked = !line_linked;
    if (line_call ? ($urandom_range(0, 14) == 0) : ($urandom_range(0, 49) == 0))
      line_call = !line_call;
    pick = $urandom_range(0, 99);
    if (pick < 84)      req.func = asas_pkg::FUNC_TICK;
    else if (pick < 91) req.func = asas_pkg::FUNC_TOGGLE;
    else if (pick < 96) req.func = asas_pkg::FUNC_TEMP_BT;
    else                req.func = asas_pkg::FUNC_RSVD;
    req.bt_powered  = line_powered;
    req.bt_linked   = line_linked;
    req.call_active = line_call;
    if ($urandom_range(0, 32) == 0) begin
      req.func        = 2'($urandom_range(0, 3));
      req.bt_powered  = 1'($urandom_range(0, 1));
      req.bt_linked   = 1'($urandom_range(0, 1));
      req.call_active = 1'($urandom_range(0, 1));
    end
    return req;
  endfunction

  // offer one request, with an occasional idle burst before it
  task automatic push_request(asas_pkg::item_t req, bit typed,
                              asas_pkg::result_t typed_res);
    asas_pkg::result_t res;
    @(negedge clk);
    if (!steady_flow && $urandom_range(0, 7) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.func        <= req.func;
    in_ch.bt_powered  <= req.bt_powered;
    in_ch.bt_linked   <= req.bt_linked;
    in_ch.call_active <= req.call_active;
    do @(posedge clk); while (!in_ch.ready);
    res = select_source(req);
    pending_selections.push_back(typed ? typed_res : res);
    requests_sent++;
  endtask

  // stop offering and wait for every outstanding result
  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_selections.size() != 0) @(posedge clk);
  endtask

  // one apb transfer, setup then access
  task automatic apb_access(bit wr, logic [2:0] idx, logic [31:0] wdata,
                            output logic [31:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // write all five registers, mirror them and read them back
  task automatic apply_setting(logic [23:0] startup, logic [15:0] reload,
                               logic [15:0] fallback, logic [15:0] wake, logic [15:0] temp);
    logic [31:0] vals [5];
    logic [31:0] rd;
    vals = '{32'(startup), 32'(reload), 32'(fallback), 32'(wake), 32'(temp)};
    for (int i = 0; i < 5; i++) begin
      apb_access(1'b1, 3'(i), vals[i], rd);
      case (3'(i))
        asas_pkg::REG_STARTUP_HOLD:   cfg_shadow.startup_hold_ticks   = startup;
        asas_pkg::REG_POLL_RELOAD:    cfg_shadow.poll_reload_ticks    = reload;
        asas_pkg::REG_FALLBACK_POLLS: cfg_shadow.radio_fallback_polls = fallback;
        asas_pkg::REG_BT_WAKE_HOLD:   cfg_shadow.bt_wake_hold_ticks   = wake;
        asas_pkg::REG_TEMP_BT_HOLD:   cfg_shadow.temp_bt_hold_ticks   = temp;
        default: ;
      endcase
    end
    for (int i = 0; i < 5; i++) begin
      apb_access(1'b0, 3'(i), '0, rd);
      if (rd !== vals[i]) begin
        $error("register %0d readback: expected %0h, got %0h", i, vals[i], rd);
        fail_count++;
      end
    end
    settings_used++;
  endtask

  // result receiver with random stalls and one long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_off_req = 1'b0;
      end else if (!steady_flow && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 18) - 1) @(negedge clk);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // result check against the oldest expected selection
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (pending_selections.size() == 0) begin
        $error("result with no request waiting");
        fail_count++;
      end else begin
        oldest_selection = pending_selections.pop_front();
        if (out_ch.mux_sel_a !== oldest_selection.mux_sel_a) begin
          $error("mux_sel_a: expected %0b, got %0b", oldest_selection.mux_sel_a,
                 out_ch.mux_sel_a);
          fail_count++;
        end
        if (out_ch.mux_sel_b !== oldest_selection.mux_sel_b) begin
          $error("mux_sel_b: expected %0b, got %0b", oldest_selection.mux_sel_b,
                 out_ch.mux_sel_b);
          fail_count++;
        end
        if (out_ch.bt_power_request !== oldest_selection.bt_power_request) begin
          $error("bt_power_request: expected %0b, got %0b",
                 oldest_selection.bt_power_request, out_ch.bt_power_request);
          fail_count++;
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (psel && penable && pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("audio_source_auto_selector test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // stimulus
  initial begin
    clk               = 1'b0;
    rst_n             = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    in_ch.valid       = 1'b0;
    in_ch.func        = asas_pkg::FUNC_TICK;
    in_ch.bt_powered  = 1'b0;
    in_ch.bt_linked   = 1'b0;
    in_ch.call_active = 1'b0;
    steady_flow       = 1'b0;
    hold_off_req      = 1'b0;
    fail_count        = 0;
    requests_sent     = 0;
    results_seen      = 0;
    poll_count        = 0;
    power_req_count   = 0;
    settings_used     = 0;
    idle_cycles       = 0;
    line_powered      = 1'b1;
    line_linked       = 1'b1;
    line_call         = 1'b0;

    // model state after reset
    cfg_shadow = '{asas_pkg::RST_STARTUP_HOLD, asas_pkg::RST_POLL_RELOAD,
                   asas_pkg::RST_FALLBACK_POLLS, asas_pkg::RST_BT_WAKE_HOLD,
                   asas_pkg::RST_TEMP_BT_HOLD};
    presc_count    = asas_pkg::RST_STARTUP_HOLD;
    fallback_left  = '0;
    on_bt          = 1'b1;
    link_seen      = 1'b1;
    call_held      = 1'b0;
    bt_before_call = 1'b1;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed part: every function, power request, fallback, call save and restore
    apply_setting(24'hFFFFFF, 16'd0, 16'd1, 16'd0, 16'd0);
    foreach (directed_steps[i])
      push_request(directed_steps[i].req, directed_steps[i].typed, directed_steps[i].res);
    drain();

    // random phases, from all-zero settings through maximum holds to random ones, the last one without idling
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: apply_setting(24'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        1: apply_setting(24'd23500, 16'd3, 16'd2, 16'd5, 16'd4);
        2: apply_setting(24'd1, 16'd1, 16'hFFFF, 16'd2, 16'd1);
        3: apply_setting(24'hFFFFFF, 16'hFFFF, 16'd3, 16'hFFFF, 16'hFFFF);
        default: apply_setting(24'($urandom), 16'($urandom_range(0, 7)),
                               16'($urandom_range(1, 6)), 16'($urandom_range(0, 10)),
                               16'($urandom_range(0, 10)));
      endcase
      steady_flow = (p == RANDOM_PHASES - 1);
      push_request('{asas_pkg::FUNC_TEMP_BT, 1'b1, 1'b1, 1'b0}, 1'b0, '0);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 1 && n == 60)
          hold_off_req = 1'b1;
        push_request(next_request(), 1'b0, '0);
      end
      drain();
    end

    repeat (4) @(posedge clk);
    $display("covered %0d requests and %0d results over %0d register settings",
             requests_sent, results_seen, settings_used);
    $display("model saw %0d polls and %0d bluetooth power requests",
             poll_count, power_req_count);
    if (fail_count == 0) begin
      $display("audio_source_auto_selector test passed");
    end else begin
      $display("audio_source_auto_selector test failed");
    end
    $finish;
  end

endmodule
